FILE: hdl/pcdn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcdn_pkg;

    // Store geometry
    localparam int PATH_CAPACITY = 4096;
    localparam int ADDR_W        = $clog2(PATH_CAPACITY);
    localparam int LEN_W         = ADDR_W + 1;

    // Fixed field widths of the stream payload
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 12;
    localparam int OUT_LEN_W = 13;
    localparam int CMP_W     = (LEN_W > IDX_W) ? LEN_W + 1 : IDX_W + 1;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [BYTE_W-1:0] SLASH_CHAR = 8'h2F;
    localparam logic [BYTE_W-1:0] DOT_CHAR   = 8'h2E;

    // Command codes
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              is_read;
        logic              is_slash;
        logic              final_byte;
        logic [BYTE_W-1:0] path_byte;
        logic [IDX_W-1:0]  read_index;
    } pcdn_item_t;

endpackage

`default_nettype wire

FILE: hdl/pcdn_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcdn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pcdn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pcdn_front
    import pcdn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic [0:0]  s_axis_tuser,
    output logic             item_valid,
    output pcdn_item_t       item,
    input  wire logic        item_pop
);

    pcdn_item_t         queue_reg [Q_DEPTH];
    logic [Q_PTR_W:0]   wr_ptr_reg;
    logic [Q_PTR_W:0]   wr_ptr_next;
    logic [Q_PTR_W:0]   rd_ptr_reg;
    logic [Q_PTR_W:0]   rd_ptr_next;
    logic               push;
    logic               full;
    logic               empty;
    pcdn_item_t         in_item;

    // Classify the incoming transaction
    always_comb
    begin
        in_item.is_read    = (s_axis_tuser[0] == CMD_READ);
        in_item.path_byte  = s_axis_tdata[BYTE_W-1:0];
        in_item.is_slash   = (s_axis_tdata[BYTE_W-1:0] == SLASH_CHAR);
        in_item.final_byte = s_axis_tlast;
        in_item.read_index = s_axis_tdata[BYTE_W+IDX_W-1:BYTE_W];
    end

    assign full  = (wr_ptr_reg[Q_PTR_W] != rd_ptr_reg[Q_PTR_W]) &&
                   (wr_ptr_reg[Q_PTR_W-1:0] == rd_ptr_reg[Q_PTR_W-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;
    assign item_valid    = !empty;
    assign item          = queue_reg[rd_ptr_reg[Q_PTR_W-1:0]];

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = (item_pop && !empty) ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg[Q_PTR_W-1:0]] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pcdn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pcdn_back
    import pcdn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire pcdn_item_t  item,
    output logic             item_pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PUT_B    = 3'd1;
    localparam logic [2:0] S_CLOSE    = 3'd2;
    localparam logic [2:0] S_WALK_RD  = 3'd3;
    localparam logic [2:0] S_WALK_CMP = 3'd4;
    localparam logic [2:0] S_AFTER    = 3'd5;
    localparam logic [2:0] S_READ     = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(PATH_CAPACITY);

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    pcdn_item_t           item_reg;
    pcdn_item_t           item_next;
    logic [LEN_W-1:0]     sl_reg;
    logic [LEN_W-1:0]     sl_next;
    logic [LEN_W-1:0]     ss_reg;
    logic [LEN_W-1:0]     ss_next;
    logic                 inside_reg;
    logic                 inside_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 done_reg;
    logic                 done_next;
    logic                 mid_reg;
    logic                 mid_next;
    logic                 b1dot_reg;
    logic                 b1dot_next;
    logic                 b2dot_reg;
    logic                 b2dot_next;
    logic [ADDR_W-1:0]    walk_reg;
    logic [ADDR_W-1:0]    walk_next;

    logic                 put_req;
    logic [LEN_W-1:0]     put_at;
    logic [BYTE_W-1:0]    put_data;
    logic [LEN_W-1:0]     put_ofs;
    logic [LEN_W-1:0]     sec_len;
    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [BYTE_W-1:0]    ram_rdata;
    logic                 idx_hit;
    logic                 out_load;

    logic                 m_valid_reg;
    logic [BYTE_W-1:0]    rd_byte_reg;
    logic [OUT_LEN_W-1:0] len_reg;
    logic                 m_done_reg;
    logic                 m_ovf_reg;

    assign sec_len = sl_reg - ss_reg;
    assign idx_hit = (CMP_W'(item_reg.read_index) < CMP_W'(ss_reg));

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        sl_next     = sl_reg;
        ss_next     = ss_reg;
        inside_next = inside_reg;
        ovf_next    = ovf_reg;
        done_next   = done_reg;
        mid_next    = mid_reg;
        b1dot_next  = b1dot_reg;
        b2dot_next  = b2dot_reg;
        walk_next   = walk_reg;
        put_req     = 1'b0;
        put_at      = sl_reg;
        put_data    = SLASH_CHAR;
        put_ofs     = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = walk_reg;
        item_pop    = 1'b0;
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop  = 1'b1;
                    item_next = item;
                    done_next = 1'b0;
                    mid_next  = 1'b0;
                    if (item.is_read)
                    begin
                        state_next = S_READ;
                    end
                    else if (!inside_reg)
                    begin
                        ovf_next    = 1'b0;
                        inside_next = 1'b1;
                        put_req     = 1'b1;
                        if (item.is_slash)
                        begin
                            ss_next    = '0;
                            put_at     = '0;
                            state_next = item.final_byte ? S_CLOSE : S_READ;
                        end
                        else
                        begin
                            ss_next    = sl_reg;
                            state_next = S_PUT_B;
                        end
                    end
                    else if (item.is_slash)
                    begin
                        mid_next   = 1'b1;
                        state_next = S_CLOSE;
                    end
                    else
                    begin
                        put_req    = 1'b1;
                        put_data   = item.path_byte;
                        state_next = item.final_byte ? S_CLOSE : S_READ;
                    end
                end
            end

            S_PUT_B:
            begin
                put_req    = 1'b1;
                put_data   = item_reg.path_byte;
                state_next = item_reg.final_byte ? S_CLOSE : S_READ;
            end

            S_CLOSE:
            begin
                if (sec_len <= LEN_W'(1) || (sec_len == LEN_W'(2) && b1dot_reg))
                begin
                    sl_next    = ss_reg;
                    state_next = S_AFTER;
                end
                else if (sec_len == LEN_W'(3) && b1dot_reg && b2dot_reg)
                begin
                    if (ss_reg == '0)
                    begin
                        sl_next    = '0;
                        state_next = S_AFTER;
                    end
                    else
                    begin
                        walk_next  = ADDR_W'(ss_reg - 1'b1);
                        state_next = S_WALK_RD;
                    end
                end
                else
                begin
                    ss_next    = sl_reg;
                    state_next = S_AFTER;
                end
            end

            S_WALK_RD:
            begin
                if (walk_reg == '0)
                begin
                    sl_next    = '0;
                    ss_next    = '0;
                    state_next = S_AFTER;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = walk_reg;
                    state_next = S_WALK_CMP;
                end
            end

            S_WALK_CMP:
            begin
                if (ram_rdata == SLASH_CHAR)
                begin
                    sl_next    = LEN_W'(walk_reg);
                    ss_next    = LEN_W'(walk_reg);
                    state_next = S_AFTER;
                end
                else
                begin
                    walk_next  = walk_reg - 1'b1;
                    state_next = S_WALK_RD;
                end
            end

            S_AFTER:
            begin
                if (mid_reg)
                begin
                    mid_next   = 1'b0;
                    put_req    = 1'b1;
                    state_next = item_reg.final_byte ? S_CLOSE : S_READ;
                end
                else
                begin
                    inside_next = 1'b0;
                    done_next   = 1'b1;
                    state_next  = S_READ;
                end
            end

            S_READ:
            begin
                if (ss_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(item_reg.read_index);
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Resolve the byte write: drop and flag when the store is full
        if (put_req)
        begin
            put_ofs = put_at - ss_next;
            if (put_at < CAP_LEN)
            begin
                ram_we  = 1'b1;
                sl_next = put_at + 1'b1;
                if (put_ofs == LEN_W'(1))
                begin
                    b1dot_next = (put_data == DOT_CHAR);
                end
                if (put_ofs == LEN_W'(2))
                begin
                    b2dot_next = (put_data == DOT_CHAR);
                end
            end
            else
            begin
                ovf_next = 1'b1;
                sl_next  = put_at;
            end
        end
    end

    pcdn_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(PATH_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(put_at)),
        .wdata (put_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sl_reg      <= '0;
            ss_reg      <= '0;
            inside_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            done_reg    <= 1'b0;
            mid_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sl_reg     <= sl_next;
            ss_reg     <= ss_next;
            inside_reg <= inside_next;
            ovf_reg    <= ovf_next;
            done_reg   <= done_next;
            mid_reg    <= mid_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        b1dot_reg  <= b1dot_next;
        b2dot_reg  <= b2dot_next;
        walk_reg   <= walk_next;
        if (out_load)
        begin
            m_done_reg <= done_reg;
            m_ovf_reg  <= ovf_reg;
            if (ss_reg == '0)
            begin
                len_reg     <= OUT_LEN_W'(1);
                rd_byte_reg <= (item_reg.read_index == '0) ? SLASH_CHAR : '0;
            end
            else
            begin
                len_reg     <= OUT_LEN_W'(ss_reg);
                rd_byte_reg <= idx_hit ? ram_rdata : '0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, len_reg, rd_byte_reg};
    assign m_axis_tlast  = m_done_reg;
    assign m_axis_tuser  = m_ovf_reg;

    // The open section never starts past the end of the stored path
    a_section_order: assert property (@(posedge clk) disable iff (!rst_n)
        ss_reg <= sl_reg)
        else $error("section start beyond stored length");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        sl_reg <= CAP_LEN)
        else $error("stored length beyond capacity");

    a_walk_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_CMP) |-> (LEN_W'(walk_reg) < ss_reg))
        else $error("walk-back address not below section start");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_RESP) |-> !ram_we)
        else $error("store written during result phase");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_valid_reg)
        else $error("result load did not raise valid");

endmodule

`default_nettype wire

FILE: hdl/path_change_directory_normalizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Change-directory path normalizer. The block keeps a current directory (root
// after reset) in a 4096-byte store and takes change-directory arguments one
// byte per transaction, the last byte marked by tlast. An argument that opens
// with '/' replaces the current directory, any other is appended after a '/'.
// Each section is applied as it closes: empty and "." sections are dropped and
// ".." removes the last name, never going above root. Bytes that would grow the
// path beyond capacity are dropped and the overflow flag is raised until the
// next argument starts. Every transaction, feed or read, returns exactly one
// result: the byte of the committed directory at read_index (root reads '/' at
// index 0, out-of-range reads give zero), the committed length (1 for root),
// a done mark on the final byte of an argument, and the overflow flag.
// Structure: a front stage accepts and classifies transactions into a
// four-entry queue; one sequencer in the back carries them out against a
// single-write, single-read store with a registered read. Every transaction
// ends in the read and result states; the first byte of a relative argument
// first writes the '/' before it, closing a section passes the close and
// after states (a '/' that is also the final byte closes two sections), and a
// ".." section reads stored bytes back one by one to the previous '/'. A result
// that waits on the output holds the sequencer until it is taken. The store
// needs no clearing pass after reset; the block accepts input from the first
// cycle on.

module path_change_directory_normalizer_unit
    import pcdn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // path_byte[7:0], read_index[19:8], zero pad
    input  wire logic        s_axis_tlast,   // final_byte
    input  wire logic [0:0]  s_axis_tuser,   // command[0]: 0 feed byte, 1 read
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // read_byte[7:0], current_length[20:8], zero pad
    output logic             m_axis_tlast,   // argument_done
    output logic [0:0]       m_axis_tuser    // overflow[0]
);

    pcdn_item_t item;
    logic       item_valid;
    logic       item_pop;

    // Front: accept and classify each transaction, hold it in the queue
    pcdn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    // Back: apply bytes to the store, close sections, walk back on "..",
    // and drive the registered result stage
    pcdn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
